// File: rtl/rsdf_pkg.sv
// Shared types and constants for the bus frame deframer.
// No dependencies; used by every module in rtl/.
`default_nettype none
package rsdf_pkg;

    localparam int MAX_FRAME = 512;
    localparam int CNT_W     = 10;

    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_LONG = 8'hFD;
    localparam logic [7:0] BYTE_SHRT = 8'hFE;
    localparam logic [7:0] BYTE_ESC  = 8'hFC;
    localparam logic [7:0] BYTE_ACK  = 8'hF8;
    localparam logic [7:0] ESC_MASK  = 8'h80;

    localparam logic [8:0] LEN_OFS_SHORT = 9'd7;
    localparam logic [8:0] LEN_OFS_LONG  = 9'd11;

    localparam logic [CNT_W-1:0] IDX_SHRT_LEN = CNT_W'(3);
    localparam logic [CNT_W-1:0] IDX_CTL      = CNT_W'(5);
    localparam logic [CNT_W-1:0] IDX_LONG_LEN = CNT_W'(6);
    localparam logic [CNT_W-1:0] IDX_XLEN     = CNT_W'(10);

    localparam logic [2:0] CAUSE_LEN   = 3'd0;
    localparam logic [2:0] CAUSE_ACK   = 3'd1;
    localparam logic [2:0] CAUSE_CACK  = 3'd2;
    localparam logic [2:0] CAUSE_TMO   = 3'd3;
    localparam logic [2:0] CAUSE_COLL  = 3'd4;
    localparam logic [2:0] CAUSE_OVFL  = 3'd5;

    localparam logic [1:0] REG_ONE_WAY = 2'd0;
    localparam logic [1:0] REG_IDLE    = 2'd1;
    localparam logic [1:0] REG_GAP     = 2'd2;

    localparam logic [15:0] IDLE_RST = 16'd5000;
    localparam logic [15:0] GAP_RST  = 16'd70;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       data_byte;
        logic             frame_end;
        logic [2:0]       end_cause;
        logic [CNT_W-1:0] frame_length;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t r0;
        result_t r1;
    } push_t;

    typedef struct packed {
        logic        one_way;
        logic [15:0] idle_ticks;
        logic [15:0] gap_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/rs485_frame_deframer.sv
// Top level: config registers, frame decode core and a 4-word result queue.
// A word shows on m_ in the cycle after its input is accepted (queue empty).
// Throughput: 1 input word per cycle while s_ready is high; a collision yields two result words.
// s_ready is low while more than two results are queued.
// Reset (aresetn, synchronous): frame state cleared, queue emptied,
// one_way=0, idle_ticks=5000, gap_ticks=70.
`default_nettype none
module rs485_frame_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_has_byte,
    output logic [7:0]       m_data_byte,
    output logic             m_frame_end,
    output logic [2:0]       m_end_cause,
    output logic [9:0]       m_frame_length,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    rsdf_pkg::cfg_t    cfg_reg;
    rsdf_pkg::push_t   push;
    rsdf_pkg::result_t head;
    logic              s_fire, room, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_way    <= 1'b0;
            cfg_reg.idle_ticks <= rsdf_pkg::IDLE_RST;
            cfg_reg.gap_ticks  <= rsdf_pkg::GAP_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                rsdf_pkg::REG_ONE_WAY: cfg_reg.one_way    <= pwdata[0];
                rsdf_pkg::REG_IDLE:    cfg_reg.idle_ticks <= pwdata[15:0];
                rsdf_pkg::REG_GAP:     cfg_reg.gap_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rsdf_pkg::REG_ONE_WAY: prdata = {31'd0, cfg_reg.one_way};
            rsdf_pkg::REG_IDLE:    prdata = {16'd0, cfg_reg.idle_ticks};
            rsdf_pkg::REG_GAP:     prdata = {16'd0, cfg_reg.gap_ticks};
            default:               prdata = '0;
        endcase
    end

    assign s_ready = room;
    assign s_fire  = s_valid && s_ready;

    rsdf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_func (s_func),
        .in_byte (s_rx_byte),
        .cfg     (cfg_reg),
        .push    (push)
    );

    rsdf_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop_ready  (m_ready),
        .head_valid (m_valid),
        .head       (head),
        .room       (room)
    );

    assign m_has_byte     = head.has_byte;
    assign m_data_byte    = head.data_byte;
    assign m_frame_end    = head.frame_end;
    assign m_end_cause    = head.end_cause;
    assign m_frame_length = head.frame_length;

    a_word_or_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_frame_end)
        else $error("result word with neither byte nor frame end");

    a_cause_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> m_end_cause == rsdf_pkg::CAUSE_LEN)
        else $error("end cause set on a non-final word");

    a_end_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_frame_length != '0)
        else $error("frame end with zero length");

    a_ack_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end &&
        (m_end_cause == rsdf_pkg::CAUSE_ACK || m_end_cause == rsdf_pkg::CAUSE_CACK)
        |-> m_frame_length == 10'd1 && m_data_byte == rsdf_pkg::BYTE_ACK && m_has_byte)
        else $error("malformed acknowledge frame");

endmodule
`default_nettype wire

// File: rtl/rsdf_core.sv
// Frame state and per-word decode: unescape, header length, frame end causes.
// Depends on rsdf_pkg; emits up to two result words per input word.
`default_nettype none
module rsdf_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_fire,
    input  wire logic           in_func,
    input  wire logic [7:0]     in_byte,
    input  wire rsdf_pkg::cfg_t cfg,
    output rsdf_pkg::push_t     push
);

    localparam int CW = rsdf_pkg::CNT_W;

    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [8:0]    exp_reg,   exp_next;
    logic          esc_reg,   esc_next;
    logic [7:0]    start_reg, start_next;
    logic [7:0]    ctl_reg,   ctl_next;
    logic [7:0]    len_reg,   len_next;
    logic          seen_reg,  seen_next;
    logic [15:0]   tick_reg,  tick_next;

    logic [15:0]   limit, tick_inc;
    logic          appended, is_hdr, coll, clr, ack_end;
    logic [7:0]    v, start_upd, ctl_upd, len_upd;
    logic [CW-1:0] cnt_inc;

    function automatic logic [8:0] work_out_length(
        input logic [7:0] st, input logic [7:0] ctl,
        input logic [7:0] lb, input logic [CW-1:0] c);
        logic [8:0] r;
        r = '0;
        if (st == rsdf_pkg::BYTE_LONG) begin
            if (c > rsdf_pkg::IDX_LONG_LEN) begin
                if (ctl[1:0] == 2'b11 || !ctl[3]) begin
                    r = {1'b0, lb} + rsdf_pkg::LEN_OFS_SHORT;
                end else if (c > rsdf_pkg::IDX_XLEN) begin
                    r = {1'b0, lb} + rsdf_pkg::LEN_OFS_LONG;
                end
            end
        end else if (st == rsdf_pkg::BYTE_SHRT) begin
            if (c > rsdf_pkg::IDX_SHRT_LEN) begin
                r = {1'b0, lb};
            end
        end
        return r;
    endfunction

    assign limit    = seen_reg ? cfg.gap_ticks : cfg.idle_ticks;
    assign tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign is_hdr   = (in_byte == rsdf_pkg::BYTE_LONG) || (in_byte == rsdf_pkg::BYTE_SHRT);
    assign v        = esc_reg ? (in_byte | rsdf_pkg::ESC_MASK) : in_byte;
    assign appended = esc_reg || !(in_byte == rsdf_pkg::BYTE_ESC && cnt_reg != '0);
    assign cnt_inc  = appended ? cnt_reg + CW'(1) : cnt_reg;
    assign start_upd = (appended && cnt_reg == '0) ? v : start_reg;
    assign ctl_upd   = (appended && cnt_reg == rsdf_pkg::IDX_CTL) ? v : ctl_reg;
    assign len_upd   = (appended &&
                        ((start_reg == rsdf_pkg::BYTE_SHRT && cnt_reg == rsdf_pkg::IDX_SHRT_LEN) ||
                         (start_reg == rsdf_pkg::BYTE_LONG &&
                          (cnt_reg == rsdf_pkg::IDX_LONG_LEN || cnt_reg == rsdf_pkg::IDX_XLEN))))
                       ? v : len_reg;
    assign ack_end   = appended && cnt_reg == '0 &&
                       (v == rsdf_pkg::BYTE_ACK ||
                        (cfg.one_way && v != rsdf_pkg::BYTE_LONG && v != rsdf_pkg::BYTE_SHRT));

    always_comb begin
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        esc_next   = esc_reg;
        start_next = start_reg;
        ctl_next   = ctl_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        tick_next  = tick_reg;
        push       = '0;
        clr        = 1'b0;
        coll       = 1'b0;
        if (in_fire) begin
            if (in_func) begin
                if (tick_inc >= limit) begin
                    if (cnt_reg != '0) begin
                        clr                   = 1'b1;
                        push.push0            = 1'b1;
                        push.r0.frame_end     = 1'b1;
                        push.r0.end_cause     = rsdf_pkg::CAUSE_TMO;
                        push.r0.frame_length  = cnt_reg;
                    end else begin
                        tick_next = '0;
                    end
                end else begin
                    tick_next = tick_inc;
                end
            end else if (cnt_reg == '0 && in_byte == rsdf_pkg::BYTE_NUL) begin
                tick_next = '0;
            end else begin
                tick_next = '0;
                seen_next = 1'b1;
                if (cnt_reg != '0 && is_hdr) begin
                    clr                  = 1'b1;
                    coll                 = 1'b1;
                    push.push0           = 1'b1;
                    push.r0.frame_end    = 1'b1;
                    push.r0.end_cause    = rsdf_pkg::CAUSE_COLL;
                    push.r0.frame_length = cnt_reg;
                    push.push1           = 1'b1;
                    push.r1.has_byte     = 1'b1;
                    push.r1.data_byte    = in_byte;
                    push.r1.frame_length = CW'(1);
                end else if (ack_end) begin
                    clr                  = 1'b1;
                    push.push0           = 1'b1;
                    push.r0.has_byte     = 1'b1;
                    push.r0.data_byte    = rsdf_pkg::BYTE_ACK;
                    push.r0.frame_end    = 1'b1;
                    push.r0.end_cause    = (v == rsdf_pkg::BYTE_ACK) ? rsdf_pkg::CAUSE_ACK
                                                                    : rsdf_pkg::CAUSE_CACK;
                    push.r0.frame_length = CW'(1);
                end else begin
                    esc_next   = !esc_reg && in_byte == rsdf_pkg::BYTE_ESC && cnt_reg != '0;
                    cnt_next   = cnt_inc;
                    start_next = start_upd;
                    ctl_next   = ctl_upd;
                    len_next   = len_upd;
                    push.r0.frame_length = cnt_inc;
                    push.r0.has_byte     = appended;
                    push.r0.data_byte    = appended ? v : 8'h00;
                    if (exp_reg == '0) begin
                        exp_next = work_out_length(start_upd, ctl_upd, len_upd, cnt_inc);
                    end else if ({1'b0, exp_reg} == cnt_inc) begin
                        clr               = 1'b1;
                        push.push0        = 1'b1;
                        push.r0.frame_end = 1'b1;
                        push.r0.end_cause = rsdf_pkg::CAUSE_LEN;
                    end
                    if (!clr && appended) begin
                        push.push0 = 1'b1;
                        if (cnt_inc >= CW'(rsdf_pkg::MAX_FRAME)) begin
                            clr               = 1'b1;
                            push.r0.frame_end = 1'b1;
                            push.r0.end_cause = rsdf_pkg::CAUSE_OVFL;
                        end
                    end
                end
            end
        end
        if (clr) begin
            cnt_next   = '0;
            exp_next   = '0;
            esc_next   = 1'b0;
            start_next = '0;
            ctl_next   = '0;
            len_next   = '0;
            seen_next  = 1'b0;
            tick_next  = '0;
            if (coll) begin
                cnt_next   = CW'(1);
                start_next = in_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            exp_reg   <= '0;
            esc_reg   <= 1'b0;
            start_reg <= '0;
            ctl_reg   <= '0;
            len_reg   <= '0;
            seen_reg  <= 1'b0;
            tick_reg  <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            exp_reg   <= exp_next;
            esc_reg   <= esc_next;
            start_reg <= start_next;
            ctl_reg   <= ctl_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            tick_reg  <= tick_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rsdf_outq.sv
// Small result queue between frame decode and the output channel.
// Depends on rsdf_pkg; takes one or two words per cycle, gives one.
`default_nettype none
module rsdf_outq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rsdf_pkg::push_t push,
    input  wire logic            pop_ready,
    output logic                 head_valid,
    output rsdf_pkg::result_t    head,
    output logic                 room
);

    localparam int AW = rsdf_pkg::OQ_AW;
    localparam int CW = AW + 1;

    rsdf_pkg::result_t mem [rsdf_pkg::OQ_DEPTH];

    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] lvl_reg, lvl_next;
    logic          pop;

    assign head_valid = lvl_reg != '0;
    assign head       = mem[rd_reg];
    assign pop        = head_valid && pop_ready;
    assign room       = lvl_reg <= CW'(rsdf_pkg::OQ_DEPTH - 2);

    assign wr_next  = wr_reg + AW'(push.push0) + AW'(push.push1);
    assign rd_next  = rd_reg + AW'(pop);
    assign lvl_next = lvl_reg + CW'(push.push0) + CW'(push.push1) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem[wr_reg] <= push.r0;
        end
        if (push.push1) begin
            mem[wr_reg + AW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for rs485_frame_deframer: bus bytes and ticks in, frame words out.
// An in-bench predictor tracks escapes, header lengths, collisions, timeouts and overflow.
// Depends on rtl/rsdf_pkg.sv and rtl/rs485_frame_deframer.sv.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_TICK = 1'b1;

    typedef struct {
        logic       fn;
        logic [7:0] b;
    } bus_item_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_func = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    wire         s_ready;
    wire         m_valid;
    wire         m_has_byte;
    wire  [7:0]  m_data_byte;
    wire         m_frame_end;
    wire  [2:0]  m_end_cause;
    wire  [9:0]  m_frame_length;
    wire  [31:0] prdata;
    wire         pready;

    rs485_frame_deframer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_has_byte(m_has_byte),
        .m_data_byte(m_data_byte), .m_frame_end(m_frame_end),
        .m_end_cause(m_end_cause), .m_frame_length(m_frame_length),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of the registers and frame state
    logic        cfg_one_way = 1'b0;
    logic [15:0] cfg_idle = rsdf_pkg::IDLE_RST;
    logic [15:0] cfg_gap = rsdf_pkg::GAP_RST;
    logic [9:0]  fr_cnt = '0;
    logic [8:0]  fr_want = '0;
    logic        fr_esc = 1'b0;
    logic [7:0]  fr_first = '0;
    logic [7:0]  fr_ctl = '0;
    logic [7:0]  fr_lenb = '0;
    logic        fr_seen = 1'b0;
    logic [15:0] fr_ticks = '0;

    rsdf_pkg::result_t words_due[$];
    bus_item_t         bus_items[$];
    bus_item_t         nxt;
    rsdf_pkg::result_t due_w;
    int  queued = 0;
    int  accepted = 0;
    int  mismatches = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    bit  send_jit = 1'b1;
    bit  recv_jit = 1'b1;
    bit  calm = 1'b0;
    logic hold_out = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic rsdf_pkg::result_t frame_word(logic has, logic [7:0] d, logic fin,
                                                     logic [2:0] cause, logic [9:0] n);
        rsdf_pkg::result_t w;
        w.has_byte = has;
        w.data_byte = d;
        w.frame_end = fin;
        w.end_cause = cause;
        w.frame_length = n;
        return w;
    endfunction

    task automatic add_due(input rsdf_pkg::result_t w);
        words_due.insert(words_due.size(), w);
    endtask

    task automatic clear_frame();
        fr_cnt = '0;
        fr_want = '0;
        fr_esc = 1'b0;
        fr_first = '0;
        fr_ctl = '0;
        fr_lenb = '0;
        fr_seen = 1'b0;
        fr_ticks = '0;
    endtask

    task automatic deframe(input logic fn, input logic [7:0] b);
        logic [7:0]  v;
        logic [15:0] lim;
        logic [9:0]  idx;
        logic        stored;
        v = b;
        stored = 1'b0;
        if (fn == FN_TICK) begin
            lim = fr_seen ? cfg_gap : cfg_idle;
            if (fr_ticks != 16'hFFFF) fr_ticks++;
            if (fr_ticks >= lim) begin
                if (fr_cnt != 0) begin
                    add_due(frame_word(1'b0, 8'h00, 1'b1, rsdf_pkg::CAUSE_TMO, fr_cnt));
                    clear_frame();
                end else begin
                    fr_ticks = '0;
                end
            end
            return;
        end
        if (fr_cnt == 0 && b == rsdf_pkg::BYTE_NUL) begin
            fr_ticks = '0;
            return;
        end
        fr_ticks = '0;
        fr_seen = 1'b1;
        if (fr_cnt != 0 && (b == rsdf_pkg::BYTE_LONG || b == rsdf_pkg::BYTE_SHRT)) begin
            add_due(frame_word(1'b0, 8'h00, 1'b1, rsdf_pkg::CAUSE_COLL, fr_cnt));
            clear_frame();
            fr_cnt = 10'd1;
            fr_first = b;
            add_due(frame_word(1'b1, b, 1'b0, rsdf_pkg::CAUSE_LEN, 10'd1));
            return;
        end
        if (fr_esc) begin
            fr_esc = 1'b0;
            v = b | rsdf_pkg::ESC_MASK;
            stored = 1'b1;
        end else if (b == rsdf_pkg::BYTE_ESC && fr_cnt != 0) begin
            fr_esc = 1'b1;
        end else begin
            stored = 1'b1;
        end
        if (stored) begin
            idx = fr_cnt;
            fr_cnt++;
            if (idx == 0) begin
                fr_first = v;
                if (v == rsdf_pkg::BYTE_ACK) begin
                    clear_frame();
                    add_due(frame_word(1'b1, rsdf_pkg::BYTE_ACK, 1'b1,
                                       rsdf_pkg::CAUSE_ACK, 10'd1));
                    return;
                end
                if (v != rsdf_pkg::BYTE_LONG && v != rsdf_pkg::BYTE_SHRT && cfg_one_way) begin
                    clear_frame();
                    add_due(frame_word(1'b1, rsdf_pkg::BYTE_ACK, 1'b1,
                                       rsdf_pkg::CAUSE_CACK, 10'd1));
                    return;
                end
            end
            if (idx == rsdf_pkg::IDX_CTL) fr_ctl = v;
            if (fr_first == rsdf_pkg::BYTE_SHRT && idx == rsdf_pkg::IDX_SHRT_LEN) fr_lenb = v;
            if (fr_first == rsdf_pkg::BYTE_LONG &&
                (idx == rsdf_pkg::IDX_LONG_LEN || idx == rsdf_pkg::IDX_XLEN)) fr_lenb = v;
        end
        if (fr_want == 0) begin
            if (fr_first == rsdf_pkg::BYTE_LONG) begin
                if (fr_cnt > 6) begin
                    if (fr_ctl[1:0] == 2'b11 || !fr_ctl[3])
                        fr_want = {1'b0, fr_lenb} + rsdf_pkg::LEN_OFS_SHORT;
                    else if (fr_cnt > 10)
                        fr_want = {1'b0, fr_lenb} + rsdf_pkg::LEN_OFS_LONG;
                end
            end else if (fr_first == rsdf_pkg::BYTE_SHRT) begin
                if (fr_cnt > 3) fr_want = {1'b0, fr_lenb};
            end
        end else if (fr_cnt == {1'b0, fr_want}) begin
            add_due(frame_word(stored, stored ? v : 8'h00, 1'b1, rsdf_pkg::CAUSE_LEN, fr_cnt));
            clear_frame();
            return;
        end
        if (stored && fr_cnt >= 10'(rsdf_pkg::MAX_FRAME)) begin
            add_due(frame_word(1'b1, v, 1'b1, rsdf_pkg::CAUSE_OVFL, fr_cnt));
            clear_frame();
            return;
        end
        if (stored) add_due(frame_word(1'b1, v, 1'b0, rsdf_pkg::CAUSE_LEN, fr_cnt));
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // sender
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                deframe(s_func, s_rx_byte);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if ($urandom_range(0, 63) == 0) send_jit = !send_jit;
                if (tx_gap == 0 && !calm && !hold_out && send_jit && $urandom_range(0, 5) == 0)
                    tx_gap = $urandom_range(1, 11);
                if (tx_gap != 0 || bus_items.size() == 0) begin
                    if (tx_gap != 0) tx_gap--;
                    s_valid <= 1'b0;
                end else begin
                    nxt = bus_items.pop_front();
                    s_valid <= 1'b1;
                    s_func <= nxt.fn;
                    s_rx_byte <= nxt.b;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (words_due.size() == 0) begin
                note_mismatch("word with nothing due", m_frame_length, 0);
            end else begin
                due_w = words_due.pop_front();
                if (m_has_byte !== due_w.has_byte)
                    note_mismatch("has_byte", m_has_byte, due_w.has_byte);
                if (m_data_byte !== due_w.data_byte)
                    note_mismatch("data_byte", m_data_byte, due_w.data_byte);
                if (m_frame_end !== due_w.frame_end)
                    note_mismatch("frame_end", m_frame_end, due_w.frame_end);
                if (m_end_cause !== due_w.end_cause)
                    note_mismatch("end_cause", m_end_cause, due_w.end_cause);
                if (m_frame_length !== due_w.frame_length)
                    note_mismatch("frame_length", m_frame_length, due_w.frame_length);
            end
        end
        if ($urandom_range(0, 63) == 0) recv_jit = !recv_jit;
        if (rx_stall != 0) rx_stall--;
        else if (!calm && recv_jit && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 11);
        m_ready <= !hold_out && rx_stall == 0;
    end

    // long receiver hold-off so the result queue fills and s_ready drops
    initial begin
        wait (accepted >= 420);
        @(posedge aclk);
        hold_out <= 1'b1;
        repeat (90) @(posedge aclk);
        hold_out <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic put_item(input logic fn, input logic [7:0] b);
        bus_item_t it;
        it.fn = fn;
        it.b = b;
        bus_items.insert(bus_items.size(), it);
        queued++;
    endtask

    // frame body byte, escaped where it would read as a code; other high bytes at random
    task automatic put_content(input logic [7:0] v);
        if (v[7] && (v == rsdf_pkg::BYTE_ESC || v == rsdf_pkg::BYTE_LONG ||
                     v == rsdf_pkg::BYTE_SHRT || $urandom_range(0, 5) == 0)) begin
            put_item(FN_BYTE, rsdf_pkg::BYTE_ESC);
            put_item(FN_BYTE, v & ~rsdf_pkg::ESC_MASK);
        end else begin
            put_item(FN_BYTE, v);
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rsdf_pkg::REG_ONE_WAY: cfg_one_way = val[0];
            rsdf_pkg::REG_IDLE:    cfg_idle = val[15:0];
            rsdf_pkg::REG_GAP:     cfg_gap = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic ow, input logic [15:0] idle, input logic [15:0] gap);
        reg_write(rsdf_pkg::REG_ONE_WAY, {31'b0, ow});
        reg_write(rsdf_pkg::REG_IDLE, {16'b0, idle});
        reg_write(rsdf_pkg::REG_GAP, {16'b0, gap});
    endtask

    task automatic settle();
        do @(posedge aclk); while (accepted != queued || words_due.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic queue_burst();
        logic [7:0] ctl, lb, lb2;
        int  n, k;
        bit  long_hdr;
        k = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) put_item(FN_BYTE, rsdf_pkg::BYTE_NUL);
        if (k < 30) begin
            ctl = 8'($urandom);
            lb = 8'($urandom_range(0, 10));
            lb2 = 8'($urandom_range(0, 10));
            long_hdr = !(ctl[1:0] == 2'b11 || !ctl[3]);
            n = long_hdr ? int'(lb2) + 11 : int'(lb) + 7;
            put_item(FN_BYTE, rsdf_pkg::BYTE_LONG);
            for (int i = 1; i < n; i++) begin
                if (i == 5) put_content(ctl);
                else if (i == 6) put_content(lb);
                else if (i == 10 && long_hdr) put_content(lb2);
                else put_content(8'($urandom));
                if ($urandom_range(0, 11) == 0) put_item(FN_TICK, 8'($urandom));
            end
        end else if (k < 50) begin
            lb = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(4, 16));
            put_item(FN_BYTE, rsdf_pkg::BYTE_SHRT);
            put_content(8'($urandom));
            put_content(8'($urandom));
            put_content(lb);
            n = (lb < 4) ? 4 + int'($urandom_range(0, 4)) : int'(lb);
            for (int i = 4; i < n; i++) put_content(8'($urandom));
        end else if (k < 58) begin
            put_item(FN_BYTE, rsdf_pkg::BYTE_ACK);
        end else if (k < 70) begin
            put_item(FN_BYTE, 8'($urandom));
            repeat ($urandom_range(0, 6)) put_content(8'($urandom));
            repeat ($urandom_range(0, 3)) put_item(FN_TICK, 8'($urandom));
        end else if (k < 80) begin
            put_item(FN_BYTE, 8'($urandom_range(1, 8'hF7)));
            repeat ($urandom_range(0, 4)) put_content(8'($urandom));
            if ($urandom_range(0, 3) == 0) put_item(FN_BYTE, rsdf_pkg::BYTE_ESC);
            put_item(FN_BYTE, $urandom_range(0, 1) ? rsdf_pkg::BYTE_LONG : rsdf_pkg::BYTE_SHRT);
        end else if (k < 88) begin
            repeat ($urandom_range(1, 24)) put_item(FN_TICK, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 8)) put_item(1'($urandom), 8'($urandom));
        end
    endtask

    task automatic fill_random(input int n);
        int stop;
        stop = queued + n;
        while (queued < stop) queue_burst();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        set_regs(1'b0, 16'd3, 16'd4);
        put_item(FN_TICK, 8'h00);
        put_item(FN_BYTE, rsdf_pkg::BYTE_NUL);
        put_item(FN_BYTE, rsdf_pkg::BYTE_ACK);
        // short header frame ending on the byte after its length byte
        put_item(FN_BYTE, rsdf_pkg::BYTE_SHRT);
        put_item(FN_BYTE, 8'h01);
        put_item(FN_BYTE, 8'h02);
        put_item(FN_BYTE, 8'h05);
        put_item(FN_BYTE, 8'hAA);
        // long header frame, last byte escaped
        put_item(FN_BYTE, rsdf_pkg::BYTE_LONG);
        put_item(FN_BYTE, 8'h00);
        put_item(FN_BYTE, 8'h01);
        put_item(FN_BYTE, 8'h02);
        put_item(FN_BYTE, 8'h03);
        put_item(FN_BYTE, 8'h03);
        put_item(FN_BYTE, 8'h01);
        put_item(FN_BYTE, rsdf_pkg::BYTE_ESC);
        put_item(FN_BYTE, 8'h7D);
        // collision, then ticks that stay below the gap limit with an escape left pending
        put_item(FN_BYTE, 8'h42);
        put_item(FN_BYTE, 8'h11);
        put_item(FN_BYTE, rsdf_pkg::BYTE_SHRT);
        put_item(FN_BYTE, rsdf_pkg::BYTE_ESC);
        repeat (3) put_item(FN_TICK, 8'hFF);
        settle();

        set_regs(1'b1, 16'd1, 16'd1);
        fill_random(300);
        settle();

        set_regs(1'b0, 16'hFFFF, 16'hFFFF);
        put_item(FN_BYTE, 8'h01);
        repeat (rsdf_pkg::MAX_FRAME - 1) put_content(8'($urandom));
        fill_random(300);
        settle();

        set_regs(1'b1, 16'd40, 16'd12);
        fill_random(150);
        settle();

        calm = 1'b1;
        set_regs(1'b0, rsdf_pkg::IDLE_RST, 16'd9);
        fill_random(150);
        settle();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
rtl/rsdf_pkg.sv
rtl/rsdf_core.sv
rtl/rsdf_outq.sv
rtl/rs485_frame_deframer.sv
verif/tb_top.sv
